// ===== design/depth_to_color_pixel_map_core_assert.svh =====
// Assertion macros shared by the checker of the depth-to-color mapping core.
// No dependencies; include by bare file name.
`ifndef DEPTH_TO_COLOR_PIXEL_MAP_CORE_ASSERT_SVH
`define DEPTH_TO_COLOR_PIXEL_MAP_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define DTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("depth_to_color_pixel_map_core assertion failed");

// Antecedent implies consequent in the next cycle.
`define DTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("depth_to_color_pixel_map_core assertion failed");

`endif

// ===== design/dtc_pkg.sv =====
// Shared constants, types and codes of the depth-to-color mapping core.
// No dependencies.
package dtc_pkg;

  localparam int REG_W       = 63;
  localparam int FW          = 21;
  localparam int COL_W       = 9;
  localparam int DEPTH_W     = 16;
  localparam int PC_W        = FW + COL_W + 1;
  localparam int SUM_W       = 32;
  localparam int PROD_W      = SUM_W + DEPTH_W + 1;
  localparam int VW          = 50;
  localparam int DZ_W        = 49;
  localparam int QW          = 12;
  localparam int REMW        = DZ_W + QW - 1;
  localparam int CDIM_W      = 12;
  localparam int XW          = 11;
  localparam int IDX_W       = 22;
  localparam int MUL_W       = XW + CDIM_W;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int NUM_ROWS    = 3;
  localparam int DIV_STAGES  = QW;
  localparam int NUM_STAGES  = 4 + 1 + DIV_STAGES + 2;

  localparam logic [CDIM_W-1:0]  COLOR_MAX_DIM  = 12'd2048;
  localparam logic [DEPTH_W-1:0] DEPTH_NONE     = 16'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_SATURATE = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_MAPPED  = 2'd0,
    ST_INVALID = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_OFFSET = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    status_e               status;
    logic signed [VW-1:0]  vx;
    logic signed [VW-1:0]  vy;
    logic signed [VW-1:0]  vz;
  } proj_t;

  typedef struct packed {
    status_e          status;
    logic [REMW-1:0]  rx;
    logic [REMW-1:0]  ry;
    logic [REMW-1:0]  dsh;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    qy;
  } div_t;

endpackage

// ===== design/dtc_proj.sv =====
// Four-stage projection pipeline: computes depth*M*[col,row,1] + t per axis.
// Depends on dtc_pkg.
module dtc_proj (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [3:0]                                en_i,
  input  logic                                      valid_i,
  input  logic [dtc_pkg::COL_W-1:0]                 col_i,
  input  logic [dtc_pkg::COL_W-1:0]                 row_i,
  input  logic [dtc_pkg::DEPTH_W-1:0]               depth_i,
  input  logic [dtc_pkg::NUM_ROWS-1:0][dtc_pkg::REG_W-1:0] mat_i,
  input  logic [dtc_pkg::REG_W-1:0]                 offset_i,
  output logic [3:0]                                valid_o,
  output dtc_pkg::proj_t                            proj_o
);

  logic signed [dtc_pkg::PC_W-1:0]   pc_d [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::PC_W-1:0]   pr_d [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::PC_W-1:0]   pc_q [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::PC_W-1:0]   pr_q [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::FW-1:0]     c_q  [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::SUM_W-1:0]  s_d  [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::SUM_W-1:0]  s_q  [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::PROD_W-1:0] m_d  [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::PROD_W-1:0] m_q  [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::VW-1:0]     v_d  [dtc_pkg::NUM_ROWS];
  logic signed [dtc_pkg::VW-1:0]     v_q  [dtc_pkg::NUM_ROWS];
  logic [dtc_pkg::DEPTH_W-1:0]       d1_q, d2_q;
  dtc_pkg::status_e                  st_d, st1_q, st2_q, st3_q, st4_q;
  logic [3:0]                        valid_q;

  always_comb begin
    st_d = ((depth_i == dtc_pkg::DEPTH_NONE) || (depth_i == dtc_pkg::DEPTH_SATURATE)) ?
           dtc_pkg::ST_INVALID : dtc_pkg::ST_MAPPED;
    for (int r = 0; r < dtc_pkg::NUM_ROWS; r++) begin
      pc_d[r] = dtc_pkg::PC_W'($signed(mat_i[r][dtc_pkg::FW-1:0]) * $signed({1'b0, col_i}));
      pr_d[r] = dtc_pkg::PC_W'($signed(mat_i[r][2*dtc_pkg::FW-1:dtc_pkg::FW])
                               * $signed({1'b0, row_i}));
      s_d[r]  = dtc_pkg::SUM_W'(pc_q[r]) + dtc_pkg::SUM_W'(pr_q[r]) + dtc_pkg::SUM_W'(c_q[r]);
      m_d[r]  = dtc_pkg::PROD_W'($signed({1'b0, d2_q}) * s_q[r]);
      v_d[r]  = dtc_pkg::VW'(m_q[r])
              + (dtc_pkg::VW'($signed(offset_i[dtc_pkg::FW*r +: dtc_pkg::FW])) <<< 7);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) valid_q[0] <= valid_i;
      if (en_i[1]) valid_q[1] <= valid_q[0];
      if (en_i[2]) valid_q[2] <= valid_q[1];
      if (en_i[3]) valid_q[3] <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < dtc_pkg::NUM_ROWS; r++) begin
      if (en_i[0]) begin
        pc_q[r] <= pc_d[r];
        pr_q[r] <= pr_d[r];
        c_q[r]  <= $signed(mat_i[r][3*dtc_pkg::FW-1:2*dtc_pkg::FW]);
      end
      if (en_i[1]) s_q[r] <= s_d[r];
      if (en_i[2]) m_q[r] <= m_d[r];
      if (en_i[3]) v_q[r] <= v_d[r];
    end
    if (en_i[0]) begin
      d1_q  <= depth_i;
      st1_q <= st_d;
    end
    if (en_i[1]) begin
      d2_q  <= d1_q;
      st2_q <= st1_q;
    end
    if (en_i[2]) st3_q <= st2_q;
    if (en_i[3]) st4_q <= st3_q;
  end

  assign valid_o        = valid_q;
  assign proj_o.status  = st4_q;
  assign proj_o.vx      = v_q[0];
  assign proj_o.vy      = v_q[1];
  assign proj_o.vz      = v_q[2];

endmodule

// ===== design/dtc_div_step.sv =====
// One restoring-division stage: retires one quotient bit for x and for y.
// Depends on dtc_pkg.
module dtc_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  dtc_pkg::div_t div_i,
  output logic          valid_o,
  output dtc_pkg::div_t div_o
);

  dtc_pkg::div_t div_d, div_q;
  logic          valid_q;
  logic          gx, gy;

  always_comb begin
    gx           = div_i.rx >= div_i.dsh;
    gy           = div_i.ry >= div_i.dsh;
    div_d        = div_i;
    div_d.rx     = gx ? div_i.rx - div_i.dsh : div_i.rx;
    div_d.ry     = gy ? div_i.ry - div_i.dsh : div_i.ry;
    div_d.dsh    = div_i.dsh >> 1;
    div_d.qx     = {div_i.qx[dtc_pkg::QW-2:0], gx};
    div_d.qy     = {div_i.qy[dtc_pkg::QW-2:0], gy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ===== design/depth_to_color_pixel_map_core.sv =====
// Top level of the depth-to-color pixel mapping core: config registers and pipeline.
// Depends on dtc_pkg, dtc_proj and dtc_div_step.
//
//  Channel   Direction  Handshake            Word contents
//  s_axis    in         tvalid/tready        pix_col, pix_row, depth_mm
//  m_axis    out        tvalid/tready        status, color_x, color_y, color_index
//  cfg       in         cfg_we_i (no wait)   register index and value
//
// The twelve-stage restoring divider retires one quotient bit per stage.
// One word can enter every cycle; each stage holds while the stage after it is
// full and stalled, so a bubble anywhere in the pipe is filled before it stalls.
// Reset clears the stage valid bits and loads the register reset values.
module depth_to_color_pixel_map_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // pix_col[8:0], pix_row[17:9], depth_mm[33:18], zero fill
  input  logic [dtc_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // status[1:0], color_x[12:2], color_y[23:13], color_index[45:24], zero fill
  output logic [dtc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [dtc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dtc_pkg::REG_W-1:0]         cfg_wdata_i
);

  // Configuration registers.
  logic [dtc_pkg::NUM_ROWS-1:0][dtc_pkg::REG_W-1:0] mat_q;
  logic [dtc_pkg::REG_W-1:0]  offset_q;
  logic [dtc_pkg::CDIM_W-1:0] width_q, height_q;
  logic [dtc_pkg::CDIM_W-1:0] w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q    <= '0;
      offset_q <= '0;
      width_q  <= 12'd1920;
      height_q <= 12'd1080;
    end else if (cfg_we_i) begin
      case (dtc_pkg::cfg_reg_e'(cfg_idx_i))
        dtc_pkg::REG_ROW0:   mat_q[0] <= cfg_wdata_i;
        dtc_pkg::REG_ROW1:   mat_q[1] <= cfg_wdata_i;
        dtc_pkg::REG_ROW2:   mat_q[2] <= cfg_wdata_i;
        dtc_pkg::REG_OFFSET: offset_q <= cfg_wdata_i;
        dtc_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i[dtc_pkg::CDIM_W-1:0];
        dtc_pkg::REG_HEIGHT: height_q <= cfg_wdata_i[dtc_pkg::CDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame sizes above the largest supported frame are clamped.
  assign w_eff = (width_q  > dtc_pkg::COLOR_MAX_DIM) ? dtc_pkg::COLOR_MAX_DIM : width_q;
  assign h_eff = (height_q > dtc_pkg::COLOR_MAX_DIM) ? dtc_pkg::COLOR_MAX_DIM : height_q;

  // Stage valid bits and the enable chain. Stage k loads when it is empty or
  // when stage k+1 loads; the last stage loads when it is empty or its word is taken.
  logic [dtc_pkg::NUM_STAGES-1:0] vld, en;

  always_comb begin
    en[dtc_pkg::NUM_STAGES-1] = !vld[dtc_pkg::NUM_STAGES-1] || m_axis_tready_i;
    for (int k = dtc_pkg::NUM_STAGES-2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];

  // Stages 0 to 3: projection.
  dtc_pkg::proj_t proj;

  dtc_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[3:0]),
    .valid_i (s_axis_tvalid_i),
    .col_i   (s_axis_tdata_i[8:0]),
    .row_i   (s_axis_tdata_i[17:9]),
    .depth_i (s_axis_tdata_i[33:18]),
    .mat_i   (mat_q),
    .offset_i(offset_q),
    .valid_o (vld[3:0]),
    .proj_o  (proj)
  );

  // Stage 4: divider setup. A negative numerator gives a zero quotient when
  // its magnitude is below z and a negative quotient otherwise; only the
  // zero case continues, as a zero remainder.
  dtc_pkg::div_t             setup_d, setup_q;
  logic                      setup_vld_q;
  logic                      z_bad, x_bad, y_bad;
  logic [dtc_pkg::VW-1:0]    mag_x, mag_y, zpos;

  always_comb begin
    zpos  = proj.vz;
    mag_x = -proj.vx;
    mag_y = -proj.vy;
    z_bad = proj.vz[dtc_pkg::VW-1] || (proj.vz == '0);
    x_bad = proj.vx[dtc_pkg::VW-1] && (mag_x >= zpos);
    y_bad = proj.vy[dtc_pkg::VW-1] && (mag_y >= zpos);
    setup_d.status = proj.status;
    if ((proj.status == dtc_pkg::ST_MAPPED) && (z_bad || x_bad || y_bad)) begin
      setup_d.status = dtc_pkg::ST_OUTSIDE;
    end
    setup_d.rx  = proj.vx[dtc_pkg::VW-1] ? '0 :
                  dtc_pkg::REMW'(proj.vx[dtc_pkg::VW-2:0]);
    setup_d.ry  = proj.vy[dtc_pkg::VW-1] ? '0 :
                  dtc_pkg::REMW'(proj.vy[dtc_pkg::VW-2:0]);
    setup_d.dsh = dtc_pkg::REMW'(zpos[dtc_pkg::DZ_W-1:0]) << (dtc_pkg::QW-1);
    setup_d.qx  = '0;
    setup_d.qy  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_vld_q <= 1'b0;
    end else if (en[4]) begin
      setup_vld_q <= vld[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) setup_q <= setup_d;
  end

  assign vld[4] = setup_vld_q;

  // Stages 5 to 16: divider. The top quotient bit flags a quotient beyond the
  // largest frame.
  dtc_pkg::div_t             div_chain [dtc_pkg::DIV_STAGES+1];
  logic [dtc_pkg::DIV_STAGES:0] div_vld;

  assign div_chain[0] = setup_q;
  assign div_vld[0]   = setup_vld_q;

  for (genvar i = 0; i < dtc_pkg::DIV_STAGES; i++) begin : g_div
    dtc_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[5+i]),
      .valid_i(div_vld[i]),
      .div_i  (div_chain[i]),
      .valid_o(div_vld[i+1]),
      .div_o  (div_chain[i+1])
    );
    assign vld[5+i] = div_vld[i+1];
  end

  // Stage 17: frame check and row offset product.
  localparam int RS = dtc_pkg::NUM_STAGES - 2;
  dtc_pkg::div_t                 dq;
  dtc_pkg::status_e              rs_st_d, rs_st_q;
  logic [dtc_pkg::XW-1:0]        rs_x_q, rs_y_q;
  logic [dtc_pkg::MUL_W-1:0]     rs_prod_q;
  logic                          rs_vld_q;

  assign dq = div_chain[dtc_pkg::DIV_STAGES];

  always_comb begin
    rs_st_d = dq.status;
    if ((dq.status == dtc_pkg::ST_MAPPED) &&
        (dq.qx[dtc_pkg::QW-1] || dq.qy[dtc_pkg::QW-1] ||
         (dtc_pkg::CDIM_W'(dq.qx[dtc_pkg::XW-1:0]) >= w_eff) ||
         (dtc_pkg::CDIM_W'(dq.qy[dtc_pkg::XW-1:0]) >= h_eff))) begin
      rs_st_d = dtc_pkg::ST_OUTSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_vld_q <= 1'b0;
    end else if (en[RS]) begin
      rs_vld_q <= vld[RS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[RS]) begin
      rs_st_q   <= rs_st_d;
      rs_x_q    <= dq.qx[dtc_pkg::XW-1:0];
      rs_y_q    <= dq.qy[dtc_pkg::XW-1:0];
      rs_prod_q <= dtc_pkg::MUL_W'(dq.qy[dtc_pkg::XW-1:0] * w_eff);
    end
  end

  assign vld[RS] = rs_vld_q;

  // Stage 18: output register. Fields are zero unless the pixel mapped.
  localparam int OS = dtc_pkg::NUM_STAGES - 1;
  dtc_pkg::status_e              out_st_q;
  logic [dtc_pkg::XW-1:0]        out_x_q, out_y_q;
  logic [dtc_pkg::IDX_W-1:0]     out_idx_q, idx_d;
  logic                          out_vld_q, mapped;

  assign mapped = (rs_st_q == dtc_pkg::ST_MAPPED);
  assign idx_d  = dtc_pkg::IDX_W'(rs_prod_q + dtc_pkg::MUL_W'(rs_x_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en[OS]) begin
      out_vld_q <= vld[RS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OS]) begin
      out_st_q  <= rs_st_q;
      out_x_q   <= mapped ? rs_x_q : '0;
      out_y_q   <= mapped ? rs_y_q : '0;
      out_idx_q <= mapped ? idx_d  : '0;
    end
  end

  assign vld[OS]          = out_vld_q;
  assign m_axis_tvalid_o  = out_vld_q;
  assign m_axis_tdata_o   = {2'b00, out_idx_q, out_y_q, out_x_q, out_st_q};

endmodule

// ===== design/dtc_checker.sv =====
// Port-level checker for the depth-to-color mapping core, bound to the top level.
// Depends on dtc_pkg and depth_to_color_pixel_map_core_assert.svh.
`include "depth_to_color_pixel_map_core_assert.svh"

module dtc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [dtc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  // A stalled result word holds.
  `DTC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // Status is one of the three defined codes.
  `DTC_ASSERT_NOW(a_status_code, m_axis_tvalid_o, m_axis_tdata_o[1:0] != 2'd3)

  // A pixel that did not map carries zero coordinates and index.
  `DTC_ASSERT_NOW(a_unmapped_zero, m_axis_tvalid_o && (m_axis_tdata_o[1:0] != 2'd0),
                  m_axis_tdata_o[dtc_pkg::OUT_TDATA_W-1:2] == '0)

  // With an empty output stage, or one whose word is taken, the core always takes input.
  `DTC_ASSERT_NOW(a_ready_when_taken, m_axis_tready_i || !m_axis_tvalid_o, s_axis_tready_o)

endmodule

bind depth_to_color_pixel_map_core dtc_checker u_dtc_checker (.*);
